>>> rtl/tks_pkg.sv
`timescale 1ns / 1ps
package tks_pkg;

  localparam int MAX_KEY_WORDS = 8;
  localparam int SUBKEY_PAIRS = 20;
  localparam logic [31:0] RHO = 32'h0101_0101;
  localparam logic [8:0] MDS_POLY = 9'h169;
  localparam logic [8:0] RS_POLY = 9'h14D;

  typedef struct packed {
    logic load;
    logic start;
    logic step_h;
    logic step_rs;
    logic sel_odd;
    logic [4:0] pair;
    logic [1:0] group;
  } tks_cmd_t;

  function automatic logic [3:0] ror4(input logic [3:0] v);
    return {v[0], v[3:1]};
  endfunction

  function automatic logic [3:0] qt(input logic w, input logic [1:0] t, input logic [3:0] x);
    logic [63:0] row;
    unique case ({w, t})
      3'd0: row = 64'h8_1_7_D_6_F_3_2_0_B_5_9_E_C_A_4;
      3'd1: row = 64'hE_C_B_8_1_2_3_5_F_4_A_6_7_0_9_D;
      3'd2: row = 64'hB_A_5_E_6_D_9_0_C_8_F_3_2_4_7_1;
      3'd3: row = 64'hD_7_F_4_1_2_6_E_9_B_3_0_8_5_C_A;
      3'd4: row = 64'h2_8_B_D_F_7_6_E_3_1_9_4_0_A_C_5;
      3'd5: row = 64'h1_E_2_B_4_C_3_7_6_D_A_5_F_9_0_8;
      3'd6: row = 64'h4_C_7_5_1_6_9_A_0_E_D_8_2_B_3_F;
      default: row = 64'hB_9_5_1_C_3_D_E_6_4_7_F_2_0_8_A;
    endcase
    return row[63 - 4 * x -: 4];
  endfunction

  function automatic logic [7:0] qperm(input logic w, input logic [7:0] x);
    logic [3:0] a, b, a1, b1, a2, b2, a3, b3;
    a = x[7:4];
    b = x[3:0];
    a1 = a ^ b;
    b1 = a ^ ror4(b) ^ {a[0], 3'b000};
    a2 = qt(w, 2'd0, a1);
    b2 = qt(w, 2'd1, b1);
    a3 = a2 ^ b2;
    b3 = a2 ^ ror4(b2) ^ {a2[0], 3'b000};
    return {qt(w, 2'd3, b3), qt(w, 2'd2, a3)};
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a_in, input logic [7:0] b,
                                        input logic [8:0] poly);
    logic [8:0] a;
    logic [7:0] r;
    a = {1'b0, a_in};
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ a[7:0];
      a = {a[7:0], 1'b0};
      if (a[8]) a = a ^ poly;
    end
    return r;
  endfunction

endpackage

>>> rtl/tks_ctrl.sv
`timescale 1ns / 1ps
module tks_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_acc,
  input  logic cfg_we,
  input  logic [2:0] k,
  input  logic out_free,
  output tks_pkg::tks_cmd_t cmd,
  output logic busy
);
  import tks_pkg::*;

  typedef enum logic [2:0] {IDLE, RS, H0, H1, EMIT} state_t;
  state_t state;
  logic [3:0] words_loaded;
  logic [4:0] pair;
  logic [1:0] group;
  logic [1:0] cyc;

  assign busy = state != IDLE;

  always_comb begin
    cmd = '0;
    cmd.load = in_acc;
    cmd.pair = pair;
    cmd.group = group;
    cmd.start = in_acc && ({words_loaded + 4'd1} == {k, 1'b0});
    cmd.step_rs = state == RS;
    cmd.step_h = state == H0 || state == H1;
    cmd.sel_odd = state == H1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      words_loaded <= '0;
      pair <= '0;
      group <= '0;
      cyc <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd.start) begin
            state <= RS;
            group <= '0;
            pair <= '0;
          end
          if (cfg_we || cmd.start) words_loaded <= '0;
          else if (in_acc) words_loaded <= words_loaded + 4'd1;
        end
        RS: begin
          if ({1'b0, group} == k - 3'd1) state <= H0;
          group <= group + 2'd1;
        end
        H0: state <= H1;
        H1: state <= EMIT;
        EMIT: begin
          if (out_free) begin
            if (cyc == 2'd1) begin
              cyc <= '0;
              if (pair == 5'(SUBKEY_PAIRS - 1)) state <= IDLE;
              else begin
                pair <= pair + 5'd1;
                state <= H0;
              end
            end else begin
              cyc <= cyc + 2'd1;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

>>> rtl/tks_dp.sv
`timescale 1ns / 1ps
module tks_dp (
  input  logic clk,
  input  tks_pkg::tks_cmd_t cmd,
  input  logic [31:0] key_word,
  input  logic [3:0] load_idx,
  input  logic [2:0] k,
  input  logic sub_phase,
  output logic [31:0] sub_word,
  output logic [31:0] sbox_word [4]
);
  import tks_pkg::*;

  logic [31:0] key_store [MAX_KEY_WORDS];
  logic [31:0] a_reg, b_reg;
  localparam logic [7:0] RSM [4][8] = '{
    '{8'h01, 8'hA4, 8'h55, 8'h87, 8'h5A, 8'h58, 8'hDB, 8'h9E},
    '{8'hA4, 8'h56, 8'h82, 8'hF3, 8'h1E, 8'hC6, 8'h68, 8'hE5},
    '{8'h02, 8'hA1, 8'hFC, 8'hC1, 8'h47, 8'hAE, 8'h3D, 8'h19},
    '{8'hA4, 8'h55, 8'h87, 8'h5A, 8'h58, 8'hDB, 8'h9E, 8'h03}};

  logic [31:0] l [4];
  logic [7:0] x, y [4];
  logic [31:0] hval, rsval;
  logic [31:0] sum1, sum2;

  always_comb begin
    for (int i = 0; i < 4; i++) l[i] = key_store[3'(2 * i + (cmd.sel_odd ? 1 : 0))];
    x = {2'b00, cmd.pair, cmd.sel_odd};
    for (int j = 0; j < 4; j++) y[j] = x;
    if (k >= 3'd4) begin
      y[0] = qperm(1'b1, y[0]) ^ l[3][7:0];
      y[1] = qperm(1'b0, y[1]) ^ l[3][15:8];
      y[2] = qperm(1'b0, y[2]) ^ l[3][23:16];
      y[3] = qperm(1'b1, y[3]) ^ l[3][31:24];
    end
    if (k >= 3'd3) begin
      y[0] = qperm(1'b1, y[0]) ^ l[2][7:0];
      y[1] = qperm(1'b1, y[1]) ^ l[2][15:8];
      y[2] = qperm(1'b0, y[2]) ^ l[2][23:16];
      y[3] = qperm(1'b0, y[3]) ^ l[2][31:24];
    end
    y[0] = qperm(1'b1, qperm(1'b0, qperm(1'b0, y[0]) ^ l[1][7:0]) ^ l[0][7:0]);
    y[1] = qperm(1'b0, qperm(1'b0, qperm(1'b1, y[1]) ^ l[1][15:8]) ^ l[0][15:8]);
    y[2] = qperm(1'b1, qperm(1'b1, qperm(1'b0, y[2]) ^ l[1][23:16]) ^ l[0][23:16]);
    y[3] = qperm(1'b0, qperm(1'b1, qperm(1'b1, y[3]) ^ l[1][31:24]) ^ l[0][31:24]);
    hval[7:0] = y[0] ^ gf_mul(8'hEF, y[1], MDS_POLY) ^ gf_mul(8'h5B, y[2], MDS_POLY)
              ^ gf_mul(8'h5B, y[3], MDS_POLY);
    hval[15:8] = gf_mul(8'h5B, y[0], MDS_POLY) ^ gf_mul(8'hEF, y[1], MDS_POLY)
               ^ gf_mul(8'hEF, y[2], MDS_POLY) ^ y[3];
    hval[23:16] = gf_mul(8'hEF, y[0], MDS_POLY) ^ gf_mul(8'h5B, y[1], MDS_POLY)
                ^ y[2] ^ gf_mul(8'hEF, y[3], MDS_POLY);
    hval[31:24] = gf_mul(8'hEF, y[0], MDS_POLY) ^ y[1]
                ^ gf_mul(8'hEF, y[2], MDS_POLY) ^ gf_mul(8'h5B, y[3], MDS_POLY);
    for (int i = 0; i < 4; i++) begin
      rsval[8 * i +: 8] = '0;
      for (int j = 0; j < 8; j++)
        rsval[8 * i +: 8] = rsval[8 * i +: 8]
          ^ gf_mul(RSM[i][j], key_store[{cmd.group, j[2]}][8 * j[1:0] +: 8], RS_POLY);
    end
    sum1 = a_reg + b_reg;
    sum2 = a_reg + {b_reg[30:0], 1'b0};
    sub_word = sub_phase ? {sum2[22:0], sum2[31:23]} : sum1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) key_store[load_idx[2:0]] <= key_word;
    if (cmd.step_rs) sbox_word[2'(k - 3'd1 - {1'b0, cmd.group})] <= rsval;
    if (cmd.step_h && !cmd.sel_odd) a_reg <= hval;
    if (cmd.step_h && cmd.sel_odd) b_reg <= {hval[23:0], hval[31:24]};
  end
endmodule

>>> rtl/twofish_key_schedule.sv
`timescale 1ns / 1ps
// channel  | dir | tdata                       | tuser                 | tlast
// s_axis   | in  | key_word[31:0]              | -                     | -
// m_axis   | out | out_word[31:0]              | word_kind, word_index | last_word
// cfg      | in  | key_word_pairs[2:0] (cfg_we)| -                     | -
// one key word item per cycle while idle; the final word starts the rs steps for
// the k sbox words, then per subkey pair two h evaluations and two items out,
// then k sbox items: s_axis is held off until the last sbox item is issued
// rst clears control state; a stalled m_axis holds the item and the run waits
module twofish_key_schedule (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [2:0] cfg_data,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // key_word
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_word
  output logic [6:0] m_axis_tuser,    // word_kind, word_index
  output logic m_axis_tlast
);
  import tks_pkg::*;

  logic [2:0] kreg, k;
  logic [3:0] widx;
  logic in_acc, busy, out_free;
  tks_cmd_t cmd;
  logic [31:0] sub_word;
  logic [31:0] sbox_word [4];
  logic [1:0] phase;
  logic sb_mode;
  logic [1:0] sb_i;
  logic emit_now;

  assign k = (kreg < 3'd2) ? 3'd2 : (kreg > 3'd4) ? 3'd4 : kreg;
  assign s_axis_tready = !busy && !sb_mode;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign emit_now = busy && out_free && phase != 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      kreg <= 3'd2;
      widx <= '0;
      m_axis_tvalid <= 1'b0;
      phase <= '0;
      sb_mode <= 1'b0;
      sb_i <= '0;
    end else begin
      if (cfg_we) kreg <= cfg_data;
      if (cfg_we) widx <= '0;
      else if (in_acc) widx <= cmd.start ? 4'd0 : widx + 4'd1;
      if (emit_now || (sb_mode && out_free)) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cmd.step_h && cmd.sel_odd) phase <= 2'd1;
      if (emit_now) begin
        m_axis_tdata <= sub_word;
        m_axis_tuser <= {cmd.pair, phase[1], 1'b0};
        m_axis_tlast <= 1'b0;
        phase <= (phase == 2'd1) ? 2'd2 : 2'd0;
        if (phase == 2'd2 && cmd.pair == 5'(SUBKEY_PAIRS - 1)) begin
          sb_mode <= 1'b1;
          sb_i <= '0;
        end
      end
      if (sb_mode && out_free) begin
        m_axis_tdata <= sbox_word[sb_i];
        m_axis_tuser <= {4'd0, sb_i, 1'b1};
        m_axis_tlast <= {1'b0, sb_i} == k - 3'd1;
        sb_i <= sb_i + 2'd1;
        if ({1'b0, sb_i} == k - 3'd1) sb_mode <= 1'b0;
      end
    end
  end

  tks_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_acc(in_acc), .cfg_we(cfg_we), .k(k),
    .out_free(emit_now), .cmd(cmd), .busy(busy)
  );

  tks_dp u_dp (
    .clk(clk), .cmd(cmd), .key_word(s_axis_tdata), .load_idx(widx), .k(k),
    .sub_phase(phase[1]), .sub_word(sub_word), .sbox_word(sbox_word)
  );
endmodule

>>> rtl/tks_checker.sv
`timescale 1ns / 1ps
module tks_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast,
  input logic [6:0] m_axis_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("valid dropped");
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0]) else $error("last on subkey");
  a_no_in: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> !s_axis_tready) else $error("input during run");
endmodule

bind twofish_key_schedule tks_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser)
);
